FILE: hdl/ptth_pkg.sv
// Package with the constants, codes and entry type of the per-port traffic histogram.
package ptth_pkg;

    localparam int PORT_W      = 16;
    localparam int PORT_COUNT  = 65536;
    localparam int ADDR_W      = $clog2(PORT_COUNT);
    localparam int BYTES_W     = 64;
    localparam int PKTS_W      = 32;

    localparam logic [PORT_W:0]   PORT_LIMIT = (PORT_W + 1)'(PORT_COUNT);
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(PORT_COUNT - 1);

    localparam logic [1:0] CMD_ACCOUNT = 2'd0;
    localparam logic [1:0] CMD_READ    = 2'd1;
    localparam logic [1:0] CMD_CLEAR   = 2'd2;

    localparam logic [1:0] KIND_NETFLOW = 2'd1;
    localparam logic [1:0] KIND_SFLOW   = 2'd2;

    localparam logic [1:0] PROTO_TCP = 2'd1;
    localparam logic [1:0] PROTO_UDP = 2'd2;

    typedef struct packed {
        logic [BYTES_W-1:0] tcp_bytes;
        logic [PKTS_W-1:0]  tcp_packets;
        logic [BYTES_W-1:0] udp_bytes;
        logic [PKTS_W-1:0]  udp_packets;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

FILE: hdl/ptth_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module ptth_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/per_port_traffic_histogram_core.sv
// Top level of the per-port traffic histogram: command sequencer around one counter RAM.
// An account command keeps busy high through S_MUL, S_AMT, S_WSRC and S_WDST, so a new
// account is taken only after both read-modify-writes; the two share the RAM ports.
// A read command reads the RAM on acceptance and passes through S_QDAT; the result strobe
// rises together with the registered result, and busy drops after S_QDAT. A clear
// command, and reset, sweep the RAM one entry per cycle: busy stays high until the last entry.
module per_port_traffic_histogram_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_command,
    input  logic [1:0]                  i_record_kind,
    input  logic [1:0]                  i_protocol,
    input  logic [15:0]                 i_ip_length,
    input  logic [15:0]                 i_record_length,
    input  logic [31:0]                 i_flow_packets,
    input  logic [15:0]                 i_flow_sampling,
    input  logic [31:0]                 i_sflow_rate,
    input  logic [ptth_pkg::PORT_W-1:0] i_sport,
    input  logic [ptth_pkg::PORT_W-1:0] i_dport,
    input  logic [ptth_pkg::PORT_W-1:0] i_query_port,
    output logic                        o_valid,
    output logic [63:0]                 o_tcp_bytes,
    output logic [31:0]                 o_tcp_packets,
    output logic [63:0]                 o_udp_bytes,
    output logic [31:0]                 o_udp_packets,
    output logic [ptth_pkg::PORT_W-1:0] o_max_tcp_port,
    output logic [ptth_pkg::PORT_W-1:0] o_max_udp_port
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_AMT   = 3'd2;
    localparam logic [2:0] S_WSRC  = 3'd3;
    localparam logic [2:0] S_WDST  = 3'd4;
    localparam logic [2:0] S_QDAT  = 3'd5;
    localparam logic [2:0] S_CLR   = 3'd6;

    logic [2:0]                        r_state;
    logic [2:0]                        n_state;
    logic [ptth_pkg::ADDR_W-1:0]       r_clr_addr;
    logic [1:0]                        r_kind;
    logic [1:0]                        r_proto;
    logic [15:0]                       r_iplen;
    logic [15:0]                       r_reclen;
    logic [31:0]                       r_fpkts;
    logic [15:0]                       r_fsamp;
    logic [31:0]                       r_srate;
    logic [ptth_pkg::PORT_W-1:0]       r_sport;
    logic [ptth_pkg::PORT_W-1:0]       r_dport;
    logic                              r_qvalid;
    logic [31:0]                       r_prod_a;
    logic [31:0]                       r_prod_p;
    logic [47:0]                       r_prod_s;
    logic [ptth_pkg::BYTES_W-1:0]      r_amt_bytes;
    logic [ptth_pkg::PKTS_W-1:0]       r_amt_pkts;
    logic [ptth_pkg::BYTES_W-1:0]      n_amt_bytes;
    logic [ptth_pkg::PKTS_W-1:0]       n_amt_pkts;
    ptth_pkg::t_entry                  r_src_entry;
    logic [ptth_pkg::PORT_W-1:0]       r_max_tcp;
    logic [ptth_pkg::PORT_W-1:0]       r_max_udp;
    logic                              r_out_valid;
    ptth_pkg::t_entry                  r_out_entry;
    logic [ptth_pkg::PORT_W-1:0]       r_out_max_tcp;
    logic [ptth_pkg::PORT_W-1:0]       r_out_max_udp;

    logic                              accept;
    logic [ptth_pkg::PORT_W-1:0]       hi_port;
    logic [47:0]                       prod_a;
    logic [47:0]                       prod_p;
    logic [47:0]                       prod_s;
    logic [47:0]                       prod_nf;
    logic                              sport_ok;
    logic                              dport_ok;
    logic                              proto_ok;
    logic                              ram_we;
    logic [ptth_pkg::ADDR_W-1:0]       ram_waddr;
    ptth_pkg::t_entry                  ram_wdata;
    logic                              ram_re;
    logic [ptth_pkg::ADDR_W-1:0]       ram_raddr;
    logic [ptth_pkg::ENTRY_W-1:0]      ram_rdata;
    ptth_pkg::t_entry                  rd_entry;
    ptth_pkg::t_entry                  base_entry;
    ptth_pkg::t_entry                  upd_entry;

    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    assign hi_port = (i_sport > i_dport) ? i_sport : i_dport;

    assign prod_a  = r_fpkts * r_reclen;
    assign prod_p  = r_fpkts * r_fsamp;
    assign prod_s  = r_reclen * r_srate;
    assign prod_nf = r_prod_a * r_fsamp;

    assign sport_ok = ({1'b0, r_sport} < ptth_pkg::PORT_LIMIT);
    assign dport_ok = ({1'b0, r_dport} < ptth_pkg::PORT_LIMIT);
    assign proto_ok = (r_proto == ptth_pkg::PROTO_TCP) || (r_proto == ptth_pkg::PROTO_UDP);

    assign rd_entry = ptth_pkg::t_entry'(ram_rdata);

    always_comb begin
        case (r_kind)
            ptth_pkg::KIND_NETFLOW: begin
                n_amt_bytes = {32'd0, prod_nf[31:0]};
                n_amt_pkts  = r_prod_p;
            end
            ptth_pkg::KIND_SFLOW: begin
                n_amt_bytes = {16'd0, r_prod_s};
                n_amt_pkts  = r_srate;
            end
            default: begin
                n_amt_bytes = {48'd0, r_iplen};
                n_amt_pkts  = 32'd1;
            end
        endcase
    end

    // When both ports are the same entry, the second update builds on the first.
    always_comb begin
        base_entry = rd_entry;
        if ((r_state == S_WDST) && (r_sport == r_dport)) begin
            base_entry = r_src_entry;
        end
        upd_entry = base_entry;
        if (r_proto == ptth_pkg::PROTO_TCP) begin
            upd_entry.tcp_bytes   = base_entry.tcp_bytes + r_amt_bytes;
            upd_entry.tcp_packets = base_entry.tcp_packets + r_amt_pkts;
        end else if (r_proto == ptth_pkg::PROTO_UDP) begin
            upd_entry.udp_bytes   = base_entry.udp_bytes + r_amt_bytes;
            upd_entry.udp_packets = base_entry.udp_packets + r_amt_pkts;
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_clr_addr;
        ram_wdata = upd_entry;
        ram_re    = 1'b0;
        ram_raddr = i_query_port[ptth_pkg::ADDR_W-1:0];
        n_state   = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_command)
                        ptth_pkg::CMD_ACCOUNT: n_state = S_MUL;
                        ptth_pkg::CMD_READ: begin
                            ram_re  = 1'b1;
                            n_state = S_QDAT;
                        end
                        ptth_pkg::CMD_CLEAR: n_state = S_CLR;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_MUL: begin
                ram_re    = 1'b1;
                ram_raddr = r_sport[ptth_pkg::ADDR_W-1:0];
                n_state   = S_AMT;
            end
            S_AMT: begin
                n_state = S_WSRC;
            end
            S_WSRC: begin
                ram_we    = proto_ok && sport_ok;
                ram_waddr = r_sport[ptth_pkg::ADDR_W-1:0];
                ram_re    = 1'b1;
                ram_raddr = r_dport[ptth_pkg::ADDR_W-1:0];
                n_state   = S_WDST;
            end
            S_WDST: begin
                ram_we    = proto_ok && dport_ok;
                ram_waddr = r_dport[ptth_pkg::ADDR_W-1:0];
                n_state   = S_IDLE;
            end
            S_QDAT: begin
                n_state = S_IDLE;
            end
            S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
                if (r_clr_addr == ptth_pkg::LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    ptth_ram #(
        .WIDTH(ptth_pkg::ENTRY_W),
        .DEPTH(ptth_pkg::PORT_COUNT)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_max_tcp   <= '0;
            r_max_udp   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= (r_state == S_QDAT);
            if (r_state == S_CLR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end else begin
                r_clr_addr <= '0;
            end
            if (accept && (i_command == ptth_pkg::CMD_CLEAR)) begin
                r_max_tcp <= '0;
                r_max_udp <= '0;
            end else if (accept && (i_command == ptth_pkg::CMD_ACCOUNT)) begin
                if ((i_protocol == ptth_pkg::PROTO_TCP) && (hi_port > r_max_tcp)) begin
                    r_max_tcp <= hi_port;
                end
                if ((i_protocol == ptth_pkg::PROTO_UDP) && (hi_port > r_max_udp)) begin
                    r_max_udp <= hi_port;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind   <= i_record_kind;
            r_proto  <= i_protocol;
            r_iplen  <= i_ip_length;
            r_reclen <= i_record_length;
            r_fpkts  <= i_flow_packets;
            r_fsamp  <= i_flow_sampling;
            r_srate  <= i_sflow_rate;
            r_sport  <= i_sport;
            r_dport  <= i_dport;
            r_qvalid <= ({1'b0, i_query_port} < ptth_pkg::PORT_LIMIT);
        end
        if (r_state == S_MUL) begin
            r_prod_a <= prod_a[31:0];
            r_prod_p <= prod_p[31:0];
            r_prod_s <= prod_s;
        end
        if (r_state == S_AMT) begin
            r_amt_bytes <= n_amt_bytes;
            r_amt_pkts  <= n_amt_pkts;
        end
        if (r_state == S_WSRC) begin
            r_src_entry <= upd_entry;
        end
        if (r_state == S_QDAT) begin
            r_out_entry   <= r_qvalid ? rd_entry : '0;
            r_out_max_tcp <= r_max_tcp;
            r_out_max_udp <= r_max_udp;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_tcp_bytes    = r_out_entry.tcp_bytes;
    assign o_tcp_packets  = r_out_entry.tcp_packets;
    assign o_udp_bytes    = r_out_entry.udp_bytes;
    assign o_udp_packets  = r_out_entry.udp_packets;
    assign o_max_tcp_port = r_out_max_tcp;
    assign o_max_udp_port = r_out_max_udp;

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the per-port traffic histogram core.
`timescale 1ns / 1ps

module tb_top;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam logic [1:0] KIND_PLAIN   = 2'd0;
    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam logic [1:0] PROTO_OTHER  = 2'd0;
    localparam logic [1:0] PROTO_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int          MAX_GAP     = 10;

    typedef struct {
        logic [1:0]  command;
        logic [1:0]  kind;
        logic [1:0]  proto;
        logic [15:0] ip_length;
        logic [15:0] record_length;
        logic [31:0] flow_packets;
        logic [15:0] flow_sampling;
        logic [31:0] sflow_rate;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] query_port;
    } t_traffic_cmd;

    typedef struct {
        logic [63:0] tcp_bytes;
        logic [31:0] tcp_packets;
        logic [63:0] udp_bytes;
        logic [31:0] udp_packets;
        logic [15:0] max_tcp_port;
        logic [15:0] max_udp_port;
    } t_port_report;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_command;
    logic [1:0]  i_record_kind;
    logic [1:0]  i_protocol;
    logic [15:0] i_ip_length;
    logic [15:0] i_record_length;
    logic [31:0] i_flow_packets;
    logic [15:0] i_flow_sampling;
    logic [31:0] i_sflow_rate;
    logic [15:0] i_sport;
    logic [15:0] i_dport;
    logic [15:0] i_query_port;
    logic        o_valid;
    logic [63:0] o_tcp_bytes;
    logic [31:0] o_tcp_packets;
    logic [63:0] o_udp_bytes;
    logic [31:0] o_udp_packets;
    logic [15:0] o_max_tcp_port;
    logic [15:0] o_max_udp_port;

    logic [63:0] tcp_bytes_tab [ptth_pkg::PORT_COUNT];
    logic [31:0] tcp_pkts_tab  [ptth_pkg::PORT_COUNT];
    logic [63:0] udp_bytes_tab [ptth_pkg::PORT_COUNT];
    logic [31:0] udp_pkts_tab  [ptth_pkg::PORT_COUNT];
    logic [15:0] tcp_top_port;
    logic [15:0] udp_top_port;

    t_port_report expected_reports [$];
    int          mismatch_count = 0;
    int unsigned cycle_count = 0;

    per_port_traffic_histogram_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_record_kind   (i_record_kind),
        .i_protocol      (i_protocol),
        .i_ip_length     (i_ip_length),
        .i_record_length (i_record_length),
        .i_flow_packets  (i_flow_packets),
        .i_flow_sampling (i_flow_sampling),
        .i_sflow_rate    (i_sflow_rate),
        .i_sport         (i_sport),
        .i_dport         (i_dport),
        .i_query_port    (i_query_port),
        .o_valid         (o_valid),
        .o_tcp_bytes     (o_tcp_bytes),
        .o_tcp_packets   (o_tcp_packets),
        .o_udp_bytes     (o_udp_bytes),
        .o_udp_packets   (o_udp_packets),
        .o_max_tcp_port  (o_max_tcp_port),
        .o_max_udp_port  (o_max_udp_port)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic void clear_counters();
        for (int p = 0; p < ptth_pkg::PORT_COUNT; p++) begin
            tcp_bytes_tab[p] = '0;
            tcp_pkts_tab[p]  = '0;
            udp_bytes_tab[p] = '0;
            udp_pkts_tab[p]  = '0;
        end
        tcp_top_port = '0;
        udp_top_port = '0;
    endfunction

    function automatic void credit_port(input logic is_tcp, input logic [15:0] port,
                                        input logic [63:0] nbytes, input logic [31:0] npkts);
        if (32'(port) < ptth_pkg::PORT_COUNT) begin
            if (is_tcp) begin
                tcp_bytes_tab[port] = tcp_bytes_tab[port] + nbytes;
                tcp_pkts_tab[port]  = tcp_pkts_tab[port] + npkts;
            end else begin
                udp_bytes_tab[port] = udp_bytes_tab[port] + nbytes;
                udp_pkts_tab[port]  = udp_pkts_tab[port] + npkts;
            end
        end
    endfunction

    function automatic void apply_traffic_cmd(input t_traffic_cmd c);
        logic [63:0]  add_bytes;
        logic [31:0]  add_pkts;
        logic [31:0]  partial;
        logic [15:0]  top;
        t_port_report r;
        case (c.command)
            ptth_pkg::CMD_ACCOUNT: begin
                add_bytes = 64'(c.ip_length);
                add_pkts  = 32'd1;
                if (c.kind == ptth_pkg::KIND_NETFLOW) begin
                    partial   = c.flow_packets * 32'(c.record_length);
                    add_bytes = 64'(32'(partial * 32'(c.flow_sampling)));
                    add_pkts  = c.flow_packets * 32'(c.flow_sampling);
                end else if (c.kind == ptth_pkg::KIND_SFLOW) begin
                    add_bytes = 64'(c.record_length) * 64'(c.sflow_rate);
                    add_pkts  = c.sflow_rate;
                end
                top = (c.sport > c.dport) ? c.sport : c.dport;
                if (c.proto == ptth_pkg::PROTO_TCP) begin
                    credit_port(1'b1, c.sport, add_bytes, add_pkts);
                    credit_port(1'b1, c.dport, add_bytes, add_pkts);
                    if (top > tcp_top_port) tcp_top_port = top;
                end else if (c.proto == ptth_pkg::PROTO_UDP) begin
                    credit_port(1'b0, c.sport, add_bytes, add_pkts);
                    credit_port(1'b0, c.dport, add_bytes, add_pkts);
                    if (top > udp_top_port) udp_top_port = top;
                end
            end
            ptth_pkg::CMD_READ: begin
                r = '{default: '0};
                if (32'(c.query_port) < ptth_pkg::PORT_COUNT) begin
                    r.tcp_bytes   = tcp_bytes_tab[c.query_port];
                    r.tcp_packets = tcp_pkts_tab[c.query_port];
                    r.udp_bytes   = udp_bytes_tab[c.query_port];
                    r.udp_packets = udp_pkts_tab[c.query_port];
                end
                r.max_tcp_port = tcp_top_port;
                r.max_udp_port = udp_top_port;
                expected_reports.push_back(r);
            end
            ptth_pkg::CMD_CLEAR: clear_counters();
            default: ;
        endcase
    endfunction

    function automatic logic [15:0] pick_port();
        logic [15:0] hot_ports [8] = '{16'd0, 16'd1, 16'd80, 16'd443,
                                       16'd1024, 16'd32768, 16'd65534, 16'd65535};
        if ($urandom_range(0, 3) != 0) return hot_ports[$urandom_range(0, 7)];
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic t_traffic_cmd random_cmd();
        t_traffic_cmd c;
        int           pick;
        c.command       = ptth_pkg::CMD_ACCOUNT;
        c.kind          = 2'($urandom_range(0, 3));
        pick            = $urandom_range(0, 19);
        c.proto         = (pick < 9) ? ptth_pkg::PROTO_TCP : (pick < 18) ? ptth_pkg::PROTO_UDP :
                          (pick == 18) ? PROTO_OTHER : PROTO_UNUSED;
        c.ip_length     = 16'($urandom_range(0, 65535));
        c.record_length = 16'($urandom_range(0, 65535));
        c.flow_packets  = $urandom();
        c.flow_sampling = 16'($urandom_range(0, 65535));
        c.sflow_rate    = $urandom();
        c.sport         = pick_port();
        c.dport         = pick_port();
        c.query_port    = pick_port();
        return c;
    endfunction

    task automatic send_cmd(input t_traffic_cmd c, input int max_gap);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_command       <= c.command;
        i_record_kind   <= c.kind;
        i_protocol      <= c.proto;
        i_ip_length     <= c.ip_length;
        i_record_length <= c.record_length;
        i_flow_packets  <= c.flow_packets;
        i_flow_sampling <= c.flow_sampling;
        i_sflow_rate    <= c.sflow_rate;
        i_sport         <= c.sport;
        i_dport         <= c.dport;
        i_query_port    <= c.query_port;
        do @(posedge i_clk); while (busy !== 1'b0);
        apply_traffic_cmd(c);
    endtask

    task automatic send_read(input logic [15:0] port);
        t_traffic_cmd c;
        c            = random_cmd();
        c.command    = ptth_pkg::CMD_READ;
        c.query_port = port;
        send_cmd(c, MAX_GAP);
    endtask

    task automatic send_account(input logic [1:0] kind, input logic [1:0] proto,
                                input logic [15:0] sport, input logic [15:0] dport);
        t_traffic_cmd c;
        c       = random_cmd();
        c.kind  = kind;
        c.proto = proto;
        c.sport = sport;
        c.dport = dport;
        send_cmd(c, MAX_GAP);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (expected_reports.size() != 0);
    endtask

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("MISMATCH: %s", msg);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
            note_mismatch($sformatf("%s expected %h actual %h", name, want, got));
    endtask

    always @(posedge i_clk) begin
        t_port_report want;
        if (i_rst_n === 1'b1 && o_valid !== 1'b0) begin
            if (expected_reports.size() == 0) begin
                note_mismatch("result strobe with no read outstanding");
            end else begin
                want = expected_reports.pop_front();
                check_field("tcp_bytes", want.tcp_bytes, o_tcp_bytes);
                check_field("tcp_packets", 64'(want.tcp_packets), 64'(o_tcp_packets));
                check_field("udp_bytes", want.udp_bytes, o_udp_bytes);
                check_field("udp_packets", 64'(want.udp_packets), 64'(o_udp_packets));
                check_field("max_tcp_port", 64'(want.max_tcp_port), 64'(o_max_tcp_port));
                check_field("max_udp_port", 64'(want.max_udp_port), 64'(o_max_udp_port));
            end
        end
    end

    task automatic test_after_reset();
        send_read(16'd0);
        send_read(16'd65535);
        send_read(pick_port());
    endtask

    task automatic test_plain_packets();
        t_traffic_cmd c;
        c           = random_cmd();
        c.kind      = KIND_PLAIN;
        c.proto     = ptth_pkg::PROTO_TCP;
        c.ip_length = 16'hFFFF;
        c.sport     = 16'd0;
        c.dport     = 16'd65535;
        send_cmd(c, MAX_GAP);
        c.proto     = ptth_pkg::PROTO_UDP;
        c.ip_length = 16'd0;
        c.sport     = 16'd65535;
        c.dport     = 16'd0;
        send_cmd(c, MAX_GAP);
        c.kind      = KIND_UNUSED;
        c.proto     = ptth_pkg::PROTO_TCP;
        c.ip_length = 16'd1500;
        c.sport     = 16'd443;
        c.dport     = 16'd443;
        send_cmd(c, MAX_GAP);
        send_read(16'd0);
        send_read(16'd65535);
        send_read(16'd443);
    endtask

    task automatic test_record_kinds();
        t_traffic_cmd c;
        c               = random_cmd();
        c.kind          = ptth_pkg::KIND_NETFLOW;
        c.proto         = ptth_pkg::PROTO_UDP;
        c.flow_packets  = 32'hFFFF_FFFF;
        c.record_length = 16'hFFFF;
        c.flow_sampling = 16'hFFFF;
        c.sport         = 16'd80;
        c.dport         = 16'd1;
        send_cmd(c, MAX_GAP);
        c.kind       = ptth_pkg::KIND_SFLOW;
        c.sflow_rate = 32'hFFFF_FFFF;
        c.sport      = 16'd80;
        c.dport      = 16'd80;
        send_cmd(c, MAX_GAP);
        c.proto      = ptth_pkg::PROTO_TCP;
        c.sflow_rate = 32'd0;
        send_cmd(c, MAX_GAP);
        send_account(ptth_pkg::KIND_NETFLOW, ptth_pkg::PROTO_TCP, 16'd1, 16'd80);
        send_read(16'd80);
        send_read(16'd1);
    endtask

    task automatic test_ignored_commands();
        t_traffic_cmd c;
        send_account(ptth_pkg::KIND_SFLOW, PROTO_OTHER, 16'd65535, 16'd80);
        send_account(KIND_PLAIN, PROTO_UNUSED, 16'd80, 16'd65535);
        c            = random_cmd();
        c.command    = CMD_UNUSED;
        c.query_port = 16'd80;
        send_cmd(c, MAX_GAP);
        send_read(16'd80);
    endtask

    task automatic test_interval_clear();
        t_traffic_cmd c;
        c         = random_cmd();
        c.command = ptth_pkg::CMD_CLEAR;
        send_cmd(c, MAX_GAP);
        send_read(16'd80);
        send_read(16'd65535);
    endtask

    task automatic test_random_traffic();
        t_traffic_cmd c;
        int           max_gap;
        int           clears;
        int           pick;
        clears  = 0;
        max_gap = MAX_GAP;
        for (int n = 0; n < 400; n++) begin
            if (n % 40 == 0) max_gap = ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP;
            if (n == 200) wait_drained();
            c    = random_cmd();
            pick = $urandom_range(0, 99);
            if (pick < 68) begin
                c.command = ptth_pkg::CMD_ACCOUNT;
            end else if (pick < 94) begin
                c.command = ptth_pkg::CMD_READ;
            end else if (pick < 97) begin
                c.command = CMD_UNUSED;
            end else if (clears < 3) begin
                c.command = ptth_pkg::CMD_CLEAR;
                clears++;
            end else begin
                c.command = ptth_pkg::CMD_READ;
            end
            send_cmd(c, max_gap);
        end
    endtask

    initial begin
        clear_counters();
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_command       <= ptth_pkg::CMD_ACCOUNT;
        i_record_kind   <= KIND_PLAIN;
        i_protocol      <= PROTO_OTHER;
        i_ip_length     <= '0;
        i_record_length <= '0;
        i_flow_packets  <= '0;
        i_flow_sampling <= '0;
        i_sflow_rate    <= '0;
        i_sport         <= '0;
        i_dport         <= '0;
        i_query_port    <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_after_reset();
        test_plain_packets();
        test_record_kinds();
        test_ignored_commands();
        test_interval_clear();
        test_random_traffic();

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_reports.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
